[src/ue8_pkg.sv]
// Package for the backslash-u escape to UTF-8 decoder.
// Holds the channel payload types, the escape phase enum and the byte constants.
// No dependencies.
`default_nettype none

package ue8_pkg;

   // Most result bytes one input byte can cause
   localparam int unsigned MaxBurst = 6;
   localparam int unsigned BurstIdxW = 3;

   localparam logic [7:0] BACKSLASH = 8'h5C;
   localparam logic [7:0] LETTER_U  = 8'h75;

   localparam logic [15:0] ONE_BYTE_MAX = 16'h007F;
   localparam logic [15:0] TWO_BYTE_MAX = 16'h07FF;
   localparam logic [7:0]  LEAD_TWO     = 8'hC0;
   localparam logic [7:0]  LEAD_THREE   = 8'hE0;
   localparam logic [7:0]  CONT_MARK    = 8'h80;

   // Escape phase: what is held so far
   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,   // nothing held
      PH_BSL  = 3'd1,   // backslash held
      PH_U    = 3'd2,   // backslash and u held
      PH_D1   = 3'd3,   // plus one hex digit
      PH_D2   = 3'd4,   // plus two hex digits
      PH_D3   = 3'd5    // plus three hex digits
   } phase_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       stream_end;
   } rsp_type;

   // Result bytes caused by one input transfer
   typedef struct packed {
      logic [MaxBurst-1:0][7:0] bytes;
      logic [BurstIdxW-1:0]     count;
      logic                     last;
   } burst_type;

endpackage

`default_nettype wire

[src/unicode_escape_to_utf8_decoder_core.sv]
// Top level of the backslash-u escape to UTF-8 decoder: escape decoder and the
// result burst buffer that drains one byte per transfer. Depends on ue8_pkg, ue8_decode.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    ue8_pkg::req_type  (in_byte, in_last)
//   rsp      out        rsp_valid/stall    ue8_pkg::rsp_type  (out_byte, run_last, stream_end)
//
// An input byte is decoded in the cycle it is taken; its 0 to 6 result bytes
// go to the burst buffer and leave one per cycle unless the receiver stalls.
// A new byte is taken in the cycle the last byte of the previous burst transfers,
// so bytes that cause at most one result run at one per cycle unless the receiver
// stalls; after a longer burst the next byte waits for the whole burst to drain.
// Synchronous reset clears the escape phase and empties the buffer.
`default_nettype none

module unicode_escape_to_utf8_decoder_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire ue8_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output ue8_pkg::rsp_type       rsp_data
);

   ue8_pkg::burst_type                     burst;
   logic [ue8_pkg::MaxBurst-1:0][7:0]      buf_ff;
   logic [ue8_pkg::BurstIdxW-1:0]          cnt_ff;
   logic [ue8_pkg::BurstIdxW-1:0]          idx_ff;
   logic                                   end_ff;
   logic                                   req_go;
   logic                                   rsp_go;
   logic                                   at_tail;

   ue8_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .in_go   (req_go),
      .in_data (req_data),
      .burst   (burst)
   );

   // Handshakes
   assign rsp_valid = (cnt_ff != '0);
   assign at_tail   = (idx_ff == cnt_ff - 1'b1);
   assign rsp_go    = rsp_valid && !rsp_stall;
   assign req_stall = rsp_valid && !(rsp_go && at_tail);
   assign req_go    = req_valid && !req_stall;

   // Result payload from the buffer head
   assign rsp_data.out_byte   = buf_ff[idx_ff];
   assign rsp_data.run_last   = at_tail;
   assign rsp_data.stream_end = at_tail && end_ff;

   // Burst buffer control
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else if (req_go) begin
         cnt_ff <= burst.count;
         idx_ff <= '0;
      end else if (rsp_go && at_tail) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else if (rsp_go) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   // Burst buffer payload
   always_ff @(posedge clock) begin
      if (req_go) begin
         buf_ff <= burst.bytes;
         end_ff <= burst.last;
      end
   end

endmodule

`default_nettype wire

[src/ue8_decode.sv]
// Escape decoder: holds the escape phase, digit value and held digit bytes, and
// turns one input byte into its burst of result bytes. Depends on ue8_pkg.
`default_nettype none

module ue8_decode (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_go,
   input  wire ue8_pkg::req_type  in_data,
   output ue8_pkg::burst_type     burst
);

   ue8_pkg::phase_type phase_ff, phase_in;
   logic [11:0]        accum_ff, accum_in;
   logic [2:0][7:0]    dig_ff;

   logic               hex_ok;
   logic [3:0]         hex_val;
   logic               active;
   logic               cont;
   logic               brk;
   logic               store;
   logic               encode;
   logic [2:0]         held_q;
   ue8_pkg::phase_type mid;
   logic [1:0]         widx;
   logic [2:0][7:0]    dig_view;
   logic [15:0]        code;
   logic [7:0]         b;

   assign b = in_data.in_byte;

   // Hex digit value, either case
   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      case (b) inside
         [8'h30:8'h39]: begin
            hex_val = b[3:0];
         end
         [8'h41:8'h46], [8'h61:8'h66]: begin
            hex_val = b[3:0] + 4'd9;
         end
         default: begin
            hex_ok = 1'b0;
         end
      endcase
   end

   // Classify the byte against the current phase
   always_comb begin
      active = 1'b1;
      cont   = 1'b0;
      store  = 1'b0;
      encode = 1'b0;
      held_q = 3'd0;
      case (phase_ff)
         ue8_pkg::PH_IDLE: begin
            active = 1'b0;
         end
         ue8_pkg::PH_BSL: begin
            held_q = phase_ff;
            cont   = (b == ue8_pkg::LETTER_U);
         end
         ue8_pkg::PH_U, ue8_pkg::PH_D1, ue8_pkg::PH_D2: begin
            held_q = phase_ff;
            cont   = hex_ok;
            store  = hex_ok;
         end
         ue8_pkg::PH_D3: begin
            held_q = phase_ff;
            cont   = hex_ok;
            encode = hex_ok;
         end
         default: begin
            active = 1'b0;
         end
      endcase
      brk = active && !cont;

      // Phase after this byte, before any end-of-text flush
      if (store) begin
         mid = ue8_pkg::phase_type'(phase_ff + 3'd1);
      end else if (cont && !encode) begin
         mid = ue8_pkg::PH_U;
      end else if (!encode && b == ue8_pkg::BACKSLASH) begin
         mid = ue8_pkg::PH_BSL;
      end else begin
         mid = ue8_pkg::PH_IDLE;
      end

      // Digits as they stand after this byte is stored
      widx     = 2'(phase_ff - 3'd2);
      dig_view = dig_ff;
      if (store) begin
         dig_view[widx] = b;
      end
      code = {accum_ff, hex_val};
   end

   // Next state
   always_comb begin
      if (in_data.in_last) begin
         phase_in = ue8_pkg::PH_IDLE;
         accum_in = 12'd0;
      end else begin
         phase_in = mid;
         accum_in = store ? {accum_ff[7:0], hex_val} : 12'd0;
      end
   end

   // Burst of result bytes: break flush, pass or encode, end-of-text flush
   always_comb begin
      logic [2:0] n;
      logic [2:0] q;
      n           = 3'd0;
      burst.bytes = '0;
      burst.last  = in_data.in_last;
      q           = mid;

      if (brk) begin
         burst.bytes[n] = ue8_pkg::BACKSLASH;
         n = n + 3'd1;
         if (held_q >= 3'd2) begin
            burst.bytes[n] = ue8_pkg::LETTER_U;
            n = n + 3'd1;
         end
         for (int k = 0; k < 3; k++) begin
            if (held_q > 3'(k + 2)) begin
               burst.bytes[n] = dig_ff[k];
               n = n + 3'd1;
            end
         end
      end

      if ((!active || brk) && b != ue8_pkg::BACKSLASH) begin
         burst.bytes[n] = b;
         n = n + 3'd1;
      end

      if (encode) begin
         if (code <= ue8_pkg::ONE_BYTE_MAX) begin
            burst.bytes[n] = code[7:0];
            n = n + 3'd1;
         end else if (code <= ue8_pkg::TWO_BYTE_MAX) begin
            burst.bytes[n] = ue8_pkg::LEAD_TWO | {3'd0, code[10:6]};
            n = n + 3'd1;
            burst.bytes[n] = ue8_pkg::CONT_MARK | {2'd0, code[5:0]};
            n = n + 3'd1;
         end else begin
            burst.bytes[n] = ue8_pkg::LEAD_THREE | {4'd0, code[15:12]};
            n = n + 3'd1;
            burst.bytes[n] = ue8_pkg::CONT_MARK | {2'd0, code[11:6]};
            n = n + 3'd1;
            burst.bytes[n] = ue8_pkg::CONT_MARK | {2'd0, code[5:0]};
            n = n + 3'd1;
         end
      end

      if (in_data.in_last) begin
         if (q >= 3'd1) begin
            burst.bytes[n] = ue8_pkg::BACKSLASH;
            n = n + 3'd1;
         end
         if (q >= 3'd2) begin
            burst.bytes[n] = ue8_pkg::LETTER_U;
            n = n + 3'd1;
         end
         for (int k = 0; k < 3; k++) begin
            if (q > 3'(k + 2)) begin
               burst.bytes[n] = dig_view[k];
               n = n + 3'd1;
            end
         end
      end

      burst.count = n;
   end

   // State registers, updated on each input transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ue8_pkg::PH_IDLE;
         accum_ff <= 12'd0;
      end else if (in_go) begin
         phase_ff <= phase_in;
         accum_ff <= accum_in;
      end
   end

   // Held digit bytes, no reset
   always_ff @(posedge clock) begin
      if (in_go && store) begin
         dig_ff[widx] <= b;
      end
   end

endmodule

`default_nettype wire

[dv/tb_unicode_escape_to_utf8_decoder_core.sv]
// Testbench for unicode_escape_to_utf8_decoder_core: directed and random escaped text,
// with a scoreboard that decodes each input transfer into the UTF-8 bytes it should cause.
// Depends on ue8_pkg and the decoder RTL.

module tb_unicode_escape_to_utf8_decoder_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TotalItems = 410;
   localparam int LongHold   = 300;
   localparam int CycleLimit = 200000;
   localparam int Settle     = 20;

   // Decodes accepted input bytes into expected output bytes and checks results
   class utf8_byte_board;
      ue8_pkg::rsp_type   pending_bytes[$];
      logic [7:0]         run_bytes[$];
      ue8_pkg::phase_type phase;
      logic [7:0]         held[3];
      logic [11:0]        accum;
      int                 errors;

      function new();
         phase  = ue8_pkg::PH_IDLE;
         accum  = '0;
         errors = 0;
      endfunction

      // Held bytes go out literally, in arrival order
      function void replay_held();
         if (phase >= ue8_pkg::PH_BSL) run_bytes.push_back(ue8_pkg::BACKSLASH);
         if (phase >= ue8_pkg::PH_U) run_bytes.push_back(ue8_pkg::LETTER_U);
         for (int k = 0; k + 2 < int'(phase); k++) run_bytes.push_back(held[k]);
         phase = ue8_pkg::PH_IDLE;
         accum = '0;
      endfunction

      // A backslash opens an escape, anything else passes through
      function void take_plain(logic [7:0] b);
         if (b == ue8_pkg::BACKSLASH) begin
            phase = ue8_pkg::PH_BSL;
         end else begin
            run_bytes.push_back(b);
            phase = ue8_pkg::PH_IDLE;
         end
      endfunction

      task add_input_byte(ue8_pkg::req_type item);
         logic [7:0]       b;
         logic [3:0]       digit;
         logic             is_hex;
         logic [15:0]      code;
         ue8_pkg::rsp_type entry;
         b = item.in_byte;
         run_bytes.delete();
         is_hex = 1'b1;
         digit  = '0;
         if (b >= "0" && b <= "9") digit = 4'(b - "0");
         else if (b >= "a" && b <= "f") digit = 4'(b - "a" + 8'd10);
         else if (b >= "A" && b <= "F") digit = 4'(b - "A" + 8'd10);
         else is_hex = 1'b0;

         case (phase)
            ue8_pkg::PH_IDLE: take_plain(b);
            ue8_pkg::PH_BSL: begin
               if (b == ue8_pkg::LETTER_U) begin
                  phase = ue8_pkg::PH_U;
               end else begin
                  replay_held();
                  take_plain(b);
               end
            end
            default: begin
               if (!is_hex) begin
                  replay_held();
                  take_plain(b);
               end else if (phase != ue8_pkg::PH_D3) begin
                  held[int'(phase) - int'(ue8_pkg::PH_U)] = b;
                  accum = {accum[7:0], digit};
                  phase = ue8_pkg::phase_type'(phase + 3'd1);
               end else begin
                  // fourth digit: encode as one, two or three UTF-8 bytes
                  code = {accum, digit};
                  if (code <= ue8_pkg::ONE_BYTE_MAX) begin
                     run_bytes.push_back(code[7:0]);
                  end else if (code <= ue8_pkg::TWO_BYTE_MAX) begin
                     run_bytes.push_back(ue8_pkg::LEAD_TWO | {3'b0, code[10:6]});
                     run_bytes.push_back(ue8_pkg::CONT_MARK | {2'b0, code[5:0]});
                  end else begin
                     run_bytes.push_back(ue8_pkg::LEAD_THREE | {4'b0, code[15:12]});
                     run_bytes.push_back(ue8_pkg::CONT_MARK | {2'b0, code[11:6]});
                     run_bytes.push_back(ue8_pkg::CONT_MARK | {2'b0, code[5:0]});
                  end
                  phase = ue8_pkg::PH_IDLE;
                  accum = '0;
               end
            end
         endcase

         // end of text flushes whatever is still held
         if (item.in_last) replay_held();

         for (int k = 0; k < run_bytes.size(); k++) begin
            entry.out_byte   = run_bytes[k];
            entry.run_last   = (k == run_bytes.size() - 1);
            entry.stream_end = (k == run_bytes.size() - 1) && item.in_last;
            pending_bytes.push_back(entry);
         end
      endtask

      task report(string what);
         $display("mismatch: %s", what);
         errors++;
      endtask

      task check_output_byte(ue8_pkg::rsp_type got);
         ue8_pkg::rsp_type want;
         if (pending_bytes.size() == 0) begin
            report($sformatf("unexpected byte %h", got.out_byte));
         end else begin
            want = pending_bytes.pop_front();
            if (got.out_byte !== want.out_byte)
               report($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
            if (got.run_last !== want.run_last)
               report($sformatf("run_last %b, want %b (byte %h)",
                                got.run_last, want.run_last, want.out_byte));
            if (got.stream_end !== want.stream_end)
               report($sformatf("stream_end %b, want %b (byte %h)",
                                got.stream_end, want.stream_end, want.out_byte));
         end
      endtask
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   ue8_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   ue8_pkg::rsp_type rsp_data;

   utf8_byte_board board;
   int   sent = 0;
   int   cycles = 0;
   logic idle_on = 1'b1;
   logic hold_request = 1'b0;
   logic hold_taken = 1'b0;
   int   hold_left = 0;
   int   open_left = 0;
   int   stall_left = 0;

   unicode_escape_to_utf8_decoder_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Track both channels on each transfer
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.add_input_byte(req_data);
         if (rsp_valid && !rsp_stall) board.check_output_byte(rsp_data);
      end
   end

   // Receiver: random stall bursts, one long hold-off, none in the last part
   always @(posedge clock) begin
      if (hold_request && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left  = LongHold;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (!idle_on) begin
         rsp_stall <= 1'b0;
      end else begin
         if (open_left == 0 && stall_left == 0) begin
            open_left  = $urandom_range(1, 40);
            stall_left = $urandom_range(1, 14);
         end
         if (open_left > 0) begin
            rsp_stall <= 1'b0;
            open_left--;
         end else begin
            rsp_stall <= 1'b1;
            stall_left--;
         end
      end
   end

   // Offer one byte, maybe after an idle burst, and hold it until the transfer
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 14);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{in_byte: b, in_last: last};
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   task automatic send_text(input string s, input logic last_at_end);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], last_at_end && (i == s.len() - 1));
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      if (nib < 4'd10) return "0" + nib;
      if ($urandom_range(0, 1)) return "a" + nib - 8'd10;
      return "A" + nib - 8'd10;
   endfunction

   initial begin
      logic [7:0]  text[$];
      logic [15:0] code;
      logic [15:0] corners[8];
      logic        end_run;
      int          held_n;
      board = new();
      corners = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF,
                  16'h0800, 16'hD800, 16'hDFFF, 16'hFFFF};

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: byte extremes, each encoding length, surrogate, broken escapes, end flush
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_text("\\u007F", 1'b0);
      send_text("\\u07ff", 1'b0);
      send_text("\\uD800", 1'b0);
      send_text("\\uFFF\\", 1'b0);
      send_text("\\", 1'b1);

      // Random: mostly well-formed escapes, some cut short, some noise
      while (sent < TotalItems) begin
         if (sent >= 150 && !hold_request) hold_request <= 1'b1;
         if (sent >= 340) idle_on <= 1'b0;
         text.delete();
         end_run = ($urandom_range(0, 9) == 0);
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               case ($urandom_range(0, 3))
                  0: code = 16'($urandom_range(0, 16'h007F));
                  1: code = 16'($urandom_range(16'h0080, 16'h07FF));
                  2: code = 16'($urandom_range(16'h0800, 16'hFFFF));
                  default: code = corners[$urandom_range(0, 7)];
               endcase
               text.push_back(ue8_pkg::BACKSLASH);
               text.push_back(ue8_pkg::LETTER_U);
               for (int k = 3; k >= 0; k--) text.push_back(hex_char(code[k*4 +: 4]));
            end
            6, 7: begin
               // escape cut off after one to five held bytes
               held_n = $urandom_range(1, 5);
               text.push_back(ue8_pkg::BACKSLASH);
               if (held_n >= 2) text.push_back(ue8_pkg::LETTER_U);
               for (int k = 0; k < held_n - 2; k++)
                  text.push_back(hex_char(4'($urandom_range(0, 15))));
               if ($urandom_range(0, 3) != 0) begin
                  if ($urandom_range(0, 2) == 0) text.push_back(ue8_pkg::BACKSLASH);
                  else text.push_back(8'($urandom_range(0, 255)));
               end
            end
            default: text.push_back(8'($urandom_range(0, 255)));
         endcase
         for (int i = 0; i < text.size(); i++)
            send_byte(text[i], end_run && (i == text.size() - 1));
      end

      // Close the text so nothing stays held, then drain
      send_byte(8'h2E, 1'b1);
      req_valid <= 1'b0;
      while (board.pending_bytes.size() != 0) @(posedge clock);
      repeat (Settle) @(posedge clock);

      if (board.errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
